@@ design/stl_pkg.sv @@
`timescale 1ns / 1ps

package stl_pkg;

   typedef enum logic [2:0] {
      MODE_BLANK = 3'd0,
      MODE_WORD  = 3'd1,
      MODE_QUOTE = 3'd2,
      MODE_ESC   = 3'd3,
      MODE_SKIP  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      EV_BYTE   = 3'd0,
      EV_WEND   = 3'd1,
      EV_OP     = 3'd2,
      EV_DONE   = 3'd3,
      EV_OPENQ  = 3'd4,
      EV_ESCEND = 3'd5
   } ev_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SQUOT = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   // One classified character: one or two events, sharing the character.
   typedef struct packed {
      logic       two;
      ev_type     ev0;
      ev_type     ev1;
      logic [7:0] chr;
   } act_type;

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_LT) || (c == CH_GT) || (c == CH_PIPE) ||
             (c == CH_SEMI) || (c == CH_AMP);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

endpackage

@@ design/stl_front.sv @@
`timescale 1ns / 1ps

module stl_front import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] char_code,
   input  logic       q_full,
   output logic       full,
   output logic       act_valid,
   output act_type    act
);

   mode_type mode_ff, mode_in;
   logic     accept;
   logic     has_ev;
   logic     nul, op, hash, bsl, quo, sep;

   assign full   = q_full;
   assign accept = push & ~q_full;

   assign nul  = (char_code == CH_NUL);
   assign op   = is_op(char_code);
   assign hash = (char_code == CH_HASH);
   assign bsl  = (char_code == CH_BSL);
   assign quo  = (char_code == CH_SQUOT);
   assign sep  = is_sep(char_code);

   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         unique case (mode_ff)
            MODE_WORD: begin
               if (nul || op || (sep && !hash && !bsl && !quo)) mode_in = MODE_BLANK;
               else if (hash) mode_in = MODE_SKIP;
               else if (bsl) mode_in = MODE_ESC;
               else if (quo) mode_in = MODE_QUOTE;
               else mode_in = MODE_WORD;
            end
            MODE_QUOTE: begin
               if (nul) mode_in = MODE_BLANK;
               else if (quo) mode_in = MODE_WORD;
               else mode_in = MODE_QUOTE;
            end
            MODE_ESC: begin
               mode_in = nul ? MODE_BLANK : MODE_WORD;
            end
            MODE_SKIP: begin
               mode_in = nul ? MODE_BLANK : MODE_SKIP;
            end
            default: begin
               if (nul || op) mode_in = MODE_BLANK;
               else if (hash) mode_in = MODE_SKIP;
               else if (bsl) mode_in = MODE_ESC;
               else if (quo) mode_in = MODE_QUOTE;
               else if (sep) mode_in = MODE_BLANK;
               else mode_in = MODE_WORD;
            end
         endcase
      end
   end

   always_comb begin
      has_ev   = 1'b0;
      act.two  = 1'b0;
      act.ev0  = EV_BYTE;
      act.ev1  = EV_BYTE;
      act.chr  = char_code;
      unique case (mode_ff)
         MODE_WORD: begin
            if (nul) begin
               has_ev  = 1'b1;
               act.two = 1'b1;
               act.ev0 = EV_WEND;
               act.ev1 = EV_DONE;
            end else if (op) begin
               has_ev  = 1'b1;
               act.two = 1'b1;
               act.ev0 = EV_WEND;
               act.ev1 = EV_OP;
            end else if (hash || sep) begin
               has_ev  = 1'b1;
               act.ev0 = EV_WEND;
            end else if (!bsl && !quo) begin
               has_ev  = 1'b1;
               act.ev0 = EV_BYTE;
            end
         end
         MODE_QUOTE: begin
            if (nul) begin
               has_ev  = 1'b1;
               act.ev0 = EV_OPENQ;
            end else if (!quo) begin
               has_ev  = 1'b1;
               act.ev0 = EV_BYTE;
            end
         end
         MODE_ESC: begin
            has_ev  = 1'b1;
            act.ev0 = nul ? EV_ESCEND : EV_BYTE;
         end
         MODE_SKIP: begin
            if (nul) begin
               has_ev  = 1'b1;
               act.ev0 = EV_DONE;
            end
         end
         default: begin
            if (nul) begin
               has_ev  = 1'b1;
               act.ev0 = EV_DONE;
            end else if (op) begin
               has_ev  = 1'b1;
               act.ev0 = EV_OP;
            end else if (!hash && !bsl && !quo && !sep) begin
               has_ev  = 1'b1;
               act.ev0 = EV_BYTE;
            end
         end
      endcase
   end

   // Characters that cause no result only move the mode.
   assign act_valid = accept & has_ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BLANK;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

@@ design/stl_queue.sv @@
`timescale 1ns / 1ps

module stl_queue import stl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  act_type wr_act,
   input  logic    rd_en,
   output logic    q_full,
   output logic    q_empty,
   output act_type rd_act
);

   act_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign rd_act  = entry_ff[rd_ptr_ff];

   assign do_wr = wr_en & ~q_full;
   assign do_rd = rd_en & ~q_empty;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/stl_back.sv @@
`timescale 1ns / 1ps

module stl_back import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  act_type    head,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last
);

   logic       out_valid_ff, out_valid_in;
   ev_type     ev_ff, ev_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       phase_ff, phase_in;
   logic       load;

   // Refill the output register when it is free or being drained this cycle.
   assign load  = ~q_empty & (~out_valid_ff | pop);
   assign q_pop = load & (~head.two | phase_ff);

   always_comb begin
      ev_in        = phase_ff ? head.ev1 : head.ev0;
      byte_in      = ((ev_in == EV_BYTE) || (ev_in == EV_OP)) ? head.chr : 8'd0;
      last_in      = ~head.two | phase_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         phase_in     = head.two & ~phase_ff;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff   <= ev_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   assign empty          = ~out_valid_ff;
   assign rsp_event_res  = ev_ff;
   assign rsp_token_byte = byte_ff;
   assign rsp_last       = last_ff;

endmodule

@@ design/shell_line_tokenizer_core.sv @@
`timescale 1ns / 1ps

// Command-line tokenizer: one character per transfer on the push side (code 0
// ends a line), tokenizer events on the pop side in order. A character is
// taken every cycle while full is low; its events reach the result register
// one per cycle while that register is free or popped; a character may yield
// two events (word end followed by an operator or line done). The scanner
// mode register and a two-entry queue sit ahead of the result register, so
// push and pop stall independently. Characters that yield no event (blanks,
// quotes, escapes, comment text) are absorbed with no result.
module shell_line_tokenizer_core import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_char_code,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last
);

   logic    act_valid;
   act_type act;
   logic    q_full, q_empty, q_pop;
   act_type head;

   stl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .char_code (req_char_code),
      .q_full    (q_full),
      .full      (full),
      .act_valid (act_valid),
      .act       (act)
   );

   stl_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (act_valid),
      .wr_act  (act),
      .rd_en   (q_pop),
      .q_full  (q_full),
      .q_empty (q_empty),
      .rd_act  (head)
   );

   stl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .head           (head),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last)
   );

endmodule
